// ----- design/aik_pkg.sv -----
// aik_pkg: shared types, constants and helper functions for the arm
// inverse kinematics unit. No dependencies.
package aik_pkg;

  localparam int ANG_BITS     = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int LEN_W        = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LINK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORE_LINK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRIST_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOOL_OFFSET  = 3'd4;

  // pi/2 in Q2.30
  localparam logic signed [33:0] HALF_PI_A = 34'sd1686629713;

  typedef logic signed [63:0] wide_t;
  typedef logic signed [32:0] mop_t;
  typedef logic signed [65:0] prod_t;
  typedef logic signed [31:0] ang_t;
  typedef logic [LEN_W-1:0]   len_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // CORDIC rotation angle for step i, Q2.30
  function automatic logic signed [33:0] atan_step(input logic [4:0] i);
    logic signed [33:0] a;
    case (i)
      5'd0:    a = 34'sd843314857;
      5'd1:    a = 34'sd497837829;
      5'd2:    a = 34'sd263043837;
      5'd3:    a = 34'sd133525159;
      5'd4:    a = 34'sd67021687;
      5'd5:    a = 34'sd33543516;
      5'd6:    a = 34'sd16775851;
      5'd7:    a = 34'sd8388437;
      5'd8:    a = 34'sd4194283;
      5'd9:    a = 34'sd2097149;
      default: a = 34'(64'sd1 <<< (ANG_BITS - int'(i)));
    endcase
    return a;
  endfunction

  function automatic ang_t sat32(input logic signed [33:0] x);
    ang_t r;
    if (x > 34'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] mag64(input wide_t x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

endpackage

// ----- design/aik_in_if.sv -----
// aik_in_if: target channel (height, reach, yaw, roll) with valid/ready.
// Depends on nothing.
interface aik_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_height;
  logic signed [31:0] target_reach;
  logic signed [31:0] target_yaw;
  logic signed [31:0] target_roll;

  modport source (output valid, target_height, target_reach, target_yaw, target_roll,
                  input ready);
  modport sink   (input valid, target_height, target_reach, target_yaw, target_roll,
                  output ready);
endinterface

// ----- design/aik_out_if.sv -----
// aik_out_if: joint angle result channel with valid/ready.
// Depends on nothing.
interface aik_out_if;
  logic               valid;
  logic               ready;
  logic               solved;
  logic signed [31:0] base_angle;
  logic signed [31:0] shoulder_angle;
  logic signed [31:0] elbow_angle;
  logic signed [31:0] wrist_pitch_angle;
  logic signed [31:0] wrist_roll_angle;

  modport source (output valid, solved, base_angle, shoulder_angle, elbow_angle,
                  wrist_pitch_angle, wrist_roll_angle, input ready);
  modport sink   (input valid, solved, base_angle, shoulder_angle, elbow_angle,
                  wrist_pitch_angle, wrist_roll_angle, output ready);
endinterface

// ----- design/aik_cfg_if.sv -----
// aik_cfg_if: register write channel (index, data) with valid/ready.
// Depends on nothing.
interface aik_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/arm_inverse_kinematics_unit.sv -----
// arm_inverse_kinematics_unit: top level of the five-joint arm solver.
// Depends on aik_pkg, aik_*_if, aik_mul, aik_sqrt and aik_atan.
//
//   channel | dir | beat contents                                   | handshake
//   --------+-----+-------------------------------------------------+----------
//   cfg_ch  | in  | index (3b), data (32b, low 31 bits kept)        | valid/ready
//   in_ch   | in  | target_height, target_reach, target_yaw, roll   | valid/ready
//   out_ch  | out | solved, five joint angles                       | valid/ready
//
// Each target beat runs eight products through the shared multiplier, two
// 32-step square roots, one more product, then two arctangents of 30 divide
// steps plus 30 CORDIC steps each. A target with no solution skips the roots
// and arctangents and goes straight to the finish step.
// rst_n is synchronous; it clears control, config and the held angles.
// The result sits in an output register; a stalled out_ch holds the finish
// step but input is taken again as soon as the result is registered.
module arm_inverse_kinematics_unit
  import aik_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  aik_cfg_if.sink   cfg_ch,
  aik_in_if.sink    in_ch,
  aik_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_AB, S_CHK, S_SQA, S_SQB, S_ROOT, S_ROOTW,
    S_ND1, S_ND2, S_AT1S, S_AT1, S_AT2S, S_AT2, S_FIN
  } state_t;

  state_t state_r;

  // configuration
  len_t base_height_r, upper_link_r, fore_link_r, wrist_offset_r, tool_offset_r;

  // working registers
  ang_t        h_r, p_r, yaw_r, roll_r;
  logic [3:0]  k_r;
  wide_t       hq_r, pq_r, uq_r, fq_r, dq_r, sq_r, uh_r, up_r;
  wide_t       a_r, b_r, root_r, n2_r, t_r, d2_r;
  logic [31:0] sa_r, sb_r;
  ang_t        q2_r, q3_r;
  logic        sol_r;

  // result registers (also the held angles)
  logic        out_valid_r;
  logic        solved_r;
  ang_t        held_r [5];

  // shared units
  mop_t        mul_a, mul_b;
  prod_t       prod;
  logic        sq_start;
  logic [63:0] sq_in;
  unit_stat_t  sq_stat;
  logic [31:0] sq_root;
  logic        at_start;
  wide_t       at_num, at_den;
  unit_stat_t  at_stat;
  ang_t        at_angle;

  logic signed [32:0] u_x, f_x, d_x, s_x;
  ang_t        h_sat, p_sat;
  wide_t       prod_q, prod_h;
  logic [3:0]  k_prev;
  logic        no_sol;

  aik_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  aik_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_in),
    .stat     (sq_stat),
    .root_r   (sq_root)
  );

  aik_atan #(.FRAC_BITS(FRAC_BITS)) u_atan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (at_start),
    .num     (at_num),
    .den     (at_den),
    .stat    (at_stat),
    .angle_r (at_angle)
  );

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);

  assign out_ch.valid             = out_valid_r;
  assign out_ch.solved            = solved_r;
  assign out_ch.base_angle        = held_r[0];
  assign out_ch.shoulder_angle    = held_r[1];
  assign out_ch.elbow_angle       = held_r[2];
  assign out_ch.wrist_pitch_angle = held_r[3];
  assign out_ch.wrist_roll_angle  = held_r[4];

  always_comb begin
    u_x = $signed({2'b00, upper_link_r});
    f_x = $signed({2'b00, fore_link_r});
    d_x = u_x - f_x;
    s_x = u_x + f_x;
    // shoulder-relative height and reach, saturated
    h_sat = sat32(34'(in_ch.target_height) - 34'($signed({3'b000, base_height_r})));
    p_sat = sat32(34'(in_ch.target_reach) - 34'($signed({3'b000, wrist_offset_r}))
                  - 34'($signed({3'b000, tool_offset_r})));
    prod_q = 64'(prod >>> 2);
    prod_h = 64'(prod >>> 1);
    k_prev = k_r - 4'd1;
    no_sol = (a_r[63] && (b_r != 64'sd0) && !b_r[63]) ||
             (b_r[63] && (a_r != 64'sd0) && !a_r[63]);
  end

  // multiplier operand schedule
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL: begin
        case (k_r)
          4'd0: begin mul_a = 33'(h_r); mul_b = 33'(h_r); end
          4'd1: begin mul_a = 33'(p_r); mul_b = 33'(p_r); end
          4'd2: begin mul_a = u_x;      mul_b = u_x;      end
          4'd3: begin mul_a = f_x;      mul_b = f_x;      end
          4'd4: begin mul_a = d_x;      mul_b = d_x;      end
          4'd5: begin mul_a = s_x;      mul_b = s_x;      end
          4'd6: begin mul_a = u_x;      mul_b = 33'(h_r); end
          4'd7: begin mul_a = u_x;      mul_b = 33'(p_r); end
          default: begin mul_a = '0;    mul_b = '0;       end
        endcase
      end
      S_ROOT: begin
        mul_a = $signed({1'b0, sa_r});
        mul_b = $signed({1'b0, sb_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // square root and arctangent launches
  always_comb begin
    sq_start = 1'b0;
    sq_in    = mag64(a_r);
    if (state_r == S_CHK && !no_sol) begin
      sq_start = 1'b1;
    end else if (state_r == S_SQA && sq_stat.done) begin
      sq_start = 1'b1;
      sq_in    = mag64(b_r);
    end
    at_start = (state_r == S_AT1S) || (state_r == S_AT2S);
    at_num   = (state_r == S_AT1S) ? n2_r : root_r;
    at_den   = (state_r == S_AT1S) ? d2_r : a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      solved_r       <= 1'b0;
      base_height_r  <= '0;
      upper_link_r   <= '0;
      fore_link_r    <= '0;
      wrist_offset_r <= '0;
      tool_offset_r  <= '0;
      for (int i = 0; i < 5; i++) begin
        held_r[i] <= '0;
      end
    end else begin
      // config writes; indexes past the list drop
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_BASE_HEIGHT:  base_height_r  <= cfg_ch.data[LEN_W-1:0];
          CFG_UPPER_LINK:   upper_link_r   <= cfg_ch.data[LEN_W-1:0];
          CFG_FORE_LINK:    fore_link_r    <= cfg_ch.data[LEN_W-1:0];
          CFG_WRIST_OFFSET: wrist_offset_r <= cfg_ch.data[LEN_W-1:0];
          CFG_TOOL_OFFSET:  tool_offset_r  <= cfg_ch.data[LEN_W-1:0];
          default: ;
        endcase
      end

      // drop the result once taken; the finish step reloads it itself
      if (out_valid_r && out_ch.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            h_r     <= h_sat;
            p_r     <= p_sat;
            yaw_r   <= in_ch.target_yaw;
            roll_r  <= in_ch.target_roll;
            k_r     <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          // capture the product issued in the previous cycle
          if (k_r != 4'd0) begin
            case (k_prev)
              4'd0: hq_r <= prod_q;
              4'd1: pq_r <= prod_q;
              4'd2: uq_r <= prod_q;
              4'd3: fq_r <= prod_q;
              4'd4: dq_r <= prod_q;
              4'd5: sq_r <= prod_q;
              4'd6: uh_r <= prod_h;
              4'd7: up_r <= prod_h;
              default: ;
            endcase
          end
          k_r <= k_r + 4'd1;
          if (k_r == 4'd8) begin
            state_r <= S_AB;
          end
        end
        S_AB: begin
          a_r     <= hq_r + pq_r - dq_r;
          b_r     <= sq_r - hq_r - pq_r;
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (no_sol) begin
            sol_r   <= 1'b0;
            state_r <= S_FIN;
          end else begin
            sol_r   <= 1'b1;
            state_r <= S_SQA;
          end
        end
        S_SQA: begin
          if (sq_stat.done) begin
            sa_r    <= sq_root;
            state_r <= S_SQB;
          end
        end
        S_SQB: begin
          if (sq_stat.done) begin
            sb_r    <= sq_root;
            state_r <= S_ROOT;
          end
        end
        S_ROOT:  state_r <= S_ROOTW;
        S_ROOTW: begin
          root_r  <= prod[63:0];
          state_r <= S_ND1;
        end
        S_ND1: begin
          n2_r    <= uh_r + root_r;
          t_r     <= uq_r + up_r - fq_r;
          state_r <= S_ND2;
        end
        S_ND2: begin
          d2_r    <= t_r + hq_r + pq_r;
          state_r <= S_AT1S;
        end
        S_AT1S: state_r <= S_AT1;
        S_AT1: begin
          if (at_stat.done) begin
            q2_r    <= at_angle;
            state_r <= S_AT2S;
          end
        end
        S_AT2S: state_r <= S_AT2;
        S_AT2: begin
          if (at_stat.done) begin
            q3_r    <= at_angle;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          // wait for the output register to free up
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            solved_r    <= sol_r;
            if (sol_r) begin
              held_r[0] <= yaw_r;
              held_r[1] <= q2_r;
              held_r[2] <= q3_r;
              held_r[3] <= q3_r - q2_r;
              held_r[4] <= roll_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/aik_mul.sv -----
// aik_mul: shared registered 33x33 signed multiplier.
// Depends on aik_pkg.
module aik_mul
  import aik_pkg::*;
(
  input  logic  clk,
  input  mop_t  op_a,
  input  mop_t  op_b,
  output prod_t prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// ----- design/aik_sqrt.sv -----
// aik_sqrt: floor square root of a 64-bit value, one result bit per cycle.
// Depends on aik_pkg.
module aik_sqrt
  import aik_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output unit_stat_t  stat,
  output logic [31:0] root_r
);

  typedef enum logic {Q_IDLE, Q_RUN} qstate_t;

  qstate_t     state_r;
  logic [4:0]  cnt_r;
  logic [63:0] val_r;
  logic [35:0] rem_r;
  logic        done_r;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        fits;

  assign rem_sh = {rem_r[33:0], val_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= Q_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        Q_IDLE: begin
          if (start) begin
            val_r   <= radicand;
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= '0;
            state_r <= Q_RUN;
          end
        end
        Q_RUN: begin
          val_r <= {val_r[61:0], 2'b00};
          if (fits) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            done_r  <= 1'b1;
            state_r <= Q_IDLE;
          end
        end
        default: state_r <= Q_IDLE;
      endcase
    end
  end

  assign stat = '{busy: (state_r != Q_IDLE), done: done_r};

endmodule

// ----- design/aik_atan.sv -----
// aik_atan: doubled arctangent of num/den: restoring divide, then CORDIC
// vectoring, result rounded to FRAC_BITS fraction bits. Depends on aik_pkg.
module aik_atan
  import aik_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  wide_t      num,
  input  wide_t      den,
  output unit_stat_t stat,
  output ang_t       angle_r
);

  localparam int          SH  = ANG_BITS - FRAC_BITS;
  localparam logic [35:0] RND = 36'(64'd1 << (SH - 1));

  typedef enum logic [1:0] {A_IDLE, A_DIV, A_ROT, A_FIN} astate_t;

  astate_t            state_r;
  logic [4:0]         cnt_r;
  logic [63:0]        rem_r;
  logic [63:0]        big_r;
  logic [30:0]        q_r;
  logic signed [35:0] x_r;
  logic signed [35:0] y_r;
  logic signed [33:0] z_r;
  logic               neg_r;
  logic               swap_r;
  logic               done_r;

  logic [63:0]        un, ud, sml, bg;
  logic               sw;
  logic [64:0]        rem2;
  logic               ge;
  logic [30:0]        q_nxt;
  logic signed [35:0] dx, dy;
  logic signed [33:0] step_a;
  logic signed [33:0] zc, zr, zs;
  logic [33:0]        mz;
  logic [35:0]        mrnd;
  logic [35:0]        m;
  logic [35:0]        res;

  always_comb begin
    un   = mag64(num);
    ud   = mag64(den);
    sw   = un > ud;
    sml  = sw ? ud : un;
    bg   = sw ? un : ud;
    rem2 = {rem_r, 1'b0};
    ge   = rem2 >= {1'b0, big_r};
    q_nxt = {q_r[29:0], ge};
    dx   = y_r >>> cnt_r;
    dy   = x_r >>> cnt_r;
    step_a = atan_step(cnt_r);
    zc   = z_r[33] ? 34'sd0 : z_r;
    zr   = swap_r ? (HALF_PI_A - zc) : zc;
    zs   = neg_r ? -zr : zr;
    mz   = zs[33] ? 34'(-zs) : 34'(zs);
    // double, then round half away from zero
    mrnd = {1'b0, mz, 1'b0} + RND;
    m    = mrnd >> SH;
    res  = zs[33] ? (~m + 36'd1) : m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        A_IDLE: begin
          if (start) begin
            neg_r  <= num[63] != den[63];
            swap_r <= sw;
            big_r  <= bg;
            cnt_r  <= '0;
            x_r    <= 36'sd1 <<< ANG_BITS;
            z_r    <= '0;
            if (bg == 64'd0) begin
              angle_r <= '0;
              done_r  <= 1'b1;
            end else begin
              if (sml >= bg) begin
                rem_r <= sml - bg;
                q_r   <= 31'd1;
              end else begin
                rem_r <= sml;
                q_r   <= 31'd0;
              end
              state_r <= A_DIV;
            end
          end
        end
        A_DIV: begin
          rem_r <= ge ? 64'(rem2 - {1'b0, big_r}) : rem2[63:0];
          q_r   <= q_nxt;
          if (cnt_r == 5'(ANG_BITS - 1)) begin
            cnt_r   <= '0;
            y_r     <= $signed({5'b00000, q_nxt});
            state_r <= A_ROT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        A_ROT: begin
          if (!y_r[35]) begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + step_a;
          end else begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - step_a;
          end
          if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
            state_r <= A_FIN;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        A_FIN: begin
          angle_r <= res[31:0];
          done_r  <= 1'b1;
          state_r <= A_IDLE;
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  assign stat = '{busy: (state_r != A_IDLE), done: done_r};

endmodule

// ----- design/aik_checker.sv -----
// aik_checker: port-level assertions for arm_inverse_kinematics_unit,
// with the bind that attaches it. Depends on the top level's ports.
module aik_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_solved,
  input logic [31:0] out_base,
  input logic [31:0] out_shoulder,
  input logic [31:0] out_elbow,
  input logic [31:0] out_pitch,
  input logic [31:0] out_roll
);

  // a beat starts a multi-cycle solve
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a beat");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_base) &&
    $stable(out_shoulder) && $stable(out_elbow) && $stable(out_roll))
    else $error("result changed while stalled");

  a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_solved |-> out_pitch == out_elbow - out_shoulder)
    else $error("wrist pitch is not elbow minus shoulder");

endmodule

bind arm_inverse_kinematics_unit aik_checker u_aik_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_solved   (out_ch.solved),
  .out_base     (out_ch.base_angle),
  .out_shoulder (out_ch.shoulder_angle),
  .out_elbow    (out_ch.elbow_angle),
  .out_pitch    (out_ch.wrist_pitch_angle),
  .out_roll     (out_ch.wrist_roll_angle)
);
